[rtl/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the pressure tensor deposit block.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int ACC_W   = 48;
  localparam int COMP_N  = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_DEPOSIT = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_OUTSIDE = 2'd1,
    STS_BAD_IDX = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_INV_X = 3'd0,
    REG_INV_Y = 3'd1,
    REG_INV_Z = 3'd2,
    REG_ORG_X = 3'd3,
    REG_ORG_Y = 3'd4,
    REG_ORG_Z = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP1,
    ST_MAP2,
    ST_ADDR,
    ST_WGT,
    ST_SCL,
    ST_MAG,
    ST_PROD,
    ST_TERM,
    ST_WB,
    ST_RESP
  } state_e;

  // stage enables of one tensor component lane
  typedef struct packed {
    logic mag_en;
    logic prod_en;
    logic term_en;
  } term_ctl_t;

  // velocity axes feeding each component: xx xy xz yy yz zz
  localparam logic [1:0] COMP_A [COMP_N] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] COMP_B [COMP_N] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

endpackage

[rtl/pic_pressure_tensor_deposit.sv]
// ----------------------------------------------------------------------------
// pic_pressure_tensor_deposit
// Cloud-in-cell deposit of the kinetic pressure tensor onto a node grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   clear, load bulk velocity, deposit particle, read node. The output channel
//   (out_valid_o / out_stall_i) returns exactly one status word plus six
//   pressure components per command. Registers must be written over the APB port
//   only while the block is idle; the block itself does not enforce this.
// Sequence, one item at a time (result in the output register after the transfer):
//   any command: the next one is taken only once the block is back in idle.
//   load, read, bad species or node: straight to the response state.
//   deposit: MAP1, MAP2, then for each of 8 corner nodes address, weight, scale,
//   magnitude, product, term, write-back; then response. Outside: MAP2 to response.
//   The per-corner cost is the serial multiply chain between row read and write-back.
//   clear: one memory row per cycle, SPECIES*GRID_X*GRID_Y*GRID_Z rows, then response.
// Reset: the same sweep zeroes the pressure memory after reset; in_stall_o is
//   high until it finishes. Bulk velocities are not cleared.
// Stall: a finished result waits in the output register; the block takes the
//   next command meanwhile and holds its own result until the register frees.
// ----------------------------------------------------------------------------
module pic_pressure_tensor_deposit #(
  parameter int GRID_X  = 32,
  parameter int GRID_Y  = 32,
  parameter int GRID_Z  = 32,
  parameter int SPECIES = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptd_pkg::ADDR_W-1:0] paddr,
  input  logic [ptd_pkg::DATA_W-1:0] pwdata,
  output logic [ptd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // command channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic                       species_i,
  input  logic [14:0]                node_index_i,
  input  logic [31:0]                pos_x_i,
  input  logic [31:0]                pos_y_i,
  input  logic [31:0]                pos_z_i,
  input  logic signed [31:0]         vel_x_i,
  input  logic signed [31:0]         vel_y_i,
  input  logic signed [31:0]         vel_z_i,
  input  logic [31:0]                species_scale_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic signed [47:0]         press_xx_o,
  output logic signed [47:0]         press_xy_o,
  output logic signed [47:0]         press_xz_o,
  output logic signed [47:0]         press_yy_o,
  output logic signed [47:0]         press_yz_o,
  output logic signed [47:0]         press_zz_o
);

  localparam int NODES  = GRID_X * GRID_Y * GRID_Z;
  localparam int SLOTS  = SPECIES * NODES;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CX_W   = $clog2(GRID_X);
  localparam int CY_W   = $clog2(GRID_Y);
  localparam int CZ_W   = $clog2(GRID_Z);
  localparam int CN     = ptd_pkg::COMP_N;
  localparam int AW     = ptd_pkg::ACC_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] ACC_MIN = 48'h8000_0000_0000;

  // ---------------- configuration registers ----------------
  logic [31:0] inv_q [3];
  logic [15:0] org_q [3];
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q[0] <= 32'd65536;
      inv_q[1] <= 32'd65536;
      inv_q[2] <= 32'd65536;
      org_q[0] <= 16'd0;
      org_q[1] <= 16'd0;
      org_q[2] <= 16'd0;
    end else if (cfg_we) begin
      case (ptd_pkg::reg_idx_e'(paddr[4:2]))
        ptd_pkg::REG_INV_X: inv_q[0] <= pwdata;
        ptd_pkg::REG_INV_Y: inv_q[1] <= pwdata;
        ptd_pkg::REG_INV_Z: inv_q[2] <= pwdata;
        ptd_pkg::REG_ORG_X: org_q[0] <= pwdata[15:0];
        ptd_pkg::REG_ORG_Y: org_q[1] <= pwdata[15:0];
        ptd_pkg::REG_ORG_Z: org_q[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ptd_pkg::reg_idx_e'(paddr[4:2]))
      ptd_pkg::REG_INV_X: prdata = inv_q[0];
      ptd_pkg::REG_INV_Y: prdata = inv_q[1];
      ptd_pkg::REG_INV_Z: prdata = inv_q[2];
      ptd_pkg::REG_ORG_X: prdata = {16'b0, org_q[0]};
      ptd_pkg::REG_ORG_Y: prdata = {16'b0, org_q[1]};
      ptd_pkg::REG_ORG_Z: prdata = {16'b0, org_q[2]};
      default:            prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  ptd_pkg::state_e state_q, state_d;
  logic [2:0]        corner_q;
  logic [SLOT_W-1:0] clr_cnt_q;
  logic              clr_resp_q;
  logic              out_valid_q;
  logic              in_xfer, out_free;
  logic              sp_ok, node_ok, map_ok;
  ptd_pkg::cmd_e     in_cmd;

  // payload registers
  logic              sp_q;
  logic [31:0]       pos_q [3];
  logic signed [31:0] vel_q [3];
  logic [31:0]       scale_q;
  logic [SLOT_W-1:0] slot_q;
  logic [63:0]       cpos_q [3];
  logic [CX_W-1:0]   cx_q;
  logic [CY_W-1:0]   cy_q;
  logic [CZ_W-1:0]   cz_q;
  logic [15:0]       frac_q [3];
  logic [33:0]       wxy_q;
  logic [16:0]       w_q;
  logic [32:0]       s_q;
  logic signed [31:0] d_q [3];
  ptd_pkg::status_e  res_status_q;
  logic              res_read_q;
  logic [1:0]        out_status_q;
  logic [AW-1:0]     out_press_q [CN];

  assign in_cmd     = ptd_pkg::cmd_e'(cmd_i);
  assign in_stall_o = (state_q != ptd_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sp_ok      = (32'(species_i) < 32'(SPECIES));
  assign node_ok    = (32'(node_index_i) < 32'(NODES));

  // ---------------- memories ----------------
  logic [3*32-1:0]   bulk_mem [SLOTS];
  logic [CN*AW-1:0]  press_mem [SLOTS];
  logic [3*32-1:0]   bulk_rd_q;
  logic [CN*AW-1:0]  press_rd_q;
  logic [SLOT_W-1:0] in_slot, rd_addr, wr_addr;
  logic              bulk_we, press_we;
  logic [CN*AW-1:0]  press_wr;

  assign in_slot = (species_i ? SLOT_W'(NODES) : '0) + SLOT_W'({17'b0, node_index_i});
  assign rd_addr = (state_q == ptd_pkg::ST_IDLE) ? in_slot : slot_q;
  assign bulk_we = in_xfer && (in_cmd == ptd_pkg::CMD_LOAD) && sp_ok && node_ok;
  assign press_we = (state_q == ptd_pkg::ST_CLEAR) || (state_q == ptd_pkg::ST_WB);
  assign wr_addr  = (state_q == ptd_pkg::ST_CLEAR) ? clr_cnt_q : slot_q;

  always_ff @(posedge clk_i) begin
    if (bulk_we) begin
      bulk_mem[in_slot] <= {vel_z_i, vel_y_i, vel_x_i};
    end
    bulk_rd_q <= bulk_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (press_we) begin
      press_mem[wr_addr] <= press_wr;
    end
    press_rd_q <= press_mem[rd_addr];
  end

  // ---------------- cell mapping ----------------
  logic [31:0] ip [3];
  logic [31:0] ipo [3];
  logic [2:0]  ax_ok;
  logic [31:0] grid_lim [3];

  assign grid_lim[0] = 32'(GRID_X - 2);
  assign grid_lim[1] = 32'(GRID_Y - 2);
  assign grid_lim[2] = 32'(GRID_Z - 2);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ip[a]    = cpos_q[a][63:32];
      ipo[a]   = ip[a] - 32'(org_q[a]);
      ax_ok[a] = (ip[a] >= 32'(org_q[a])) && (ipo[a] <= grid_lim[a]);
    end
  end
  assign map_ok = &ax_ok;

  // ---------------- corner weights and slot ----------------
  logic        dx, dy, dz;
  logic [16:0] wx, wy, wz;
  logic [50:0] wprod;
  logic [48:0] sprod;
  logic [SLOT_W-1:0] node_slot;
  logic [32:0] dsub [3];
  logic signed [31:0] d_sat [3];
  logic signed [31:0] u_rd [3];

  assign dx = corner_q[0];
  assign dy = corner_q[1];
  assign dz = corner_q[2];
  assign wx = dx ? {1'b0, frac_q[0]} : (17'd65536 - {1'b0, frac_q[0]});
  assign wy = dy ? {1'b0, frac_q[1]} : (17'd65536 - {1'b0, frac_q[1]});
  assign wz = dz ? {1'b0, frac_q[2]} : (17'd65536 - {1'b0, frac_q[2]});
  assign wprod = 51'(wxy_q) * 51'(wz);
  assign sprod = 49'(w_q) * 49'(scale_q);

  assign node_slot = (sp_q ? SLOT_W'(NODES) : '0)
                   + ((SLOT_W'(CX_W'(cx_q + CX_W'(dx))) * SLOT_W'(GRID_Y)
                       + SLOT_W'(CY_W'(cy_q + CY_W'(dy)))) * SLOT_W'(GRID_Z))
                   + SLOT_W'(CZ_W'(cz_q + CZ_W'(dz)));

  assign u_rd[0] = bulk_rd_q[31:0];
  assign u_rd[1] = bulk_rd_q[63:32];
  assign u_rd[2] = bulk_rd_q[95:64];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dsub[a] = {vel_q[a][31], vel_q[a]} - {u_rd[a][31], u_rd[a]};
      if (dsub[a][32] != dsub[a][31]) begin
        d_sat[a] = dsub[a][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        d_sat[a] = dsub[a][31:0];
      end
    end
  end

  // ---------------- component lanes ----------------
  ptd_pkg::term_ctl_t term_ctl;
  logic signed [47:0] term [CN];
  logic [AW-1:0]      acc [CN];
  logic [AW:0]        acc_sum [CN];

  assign term_ctl.mag_en  = (state_q == ptd_pkg::ST_MAG);
  assign term_ctl.prod_en = (state_q == ptd_pkg::ST_PROD);
  assign term_ctl.term_en = (state_q == ptd_pkg::ST_TERM);

  for (genvar h = 0; h < CN; h++) begin : g_lane
    ptd_term_unit u_term (
      .clk_i  (clk_i),
      .ctl_i  (term_ctl),
      .da_i   (d_q[ptd_pkg::COMP_A[h]]),
      .db_i   (d_q[ptd_pkg::COMP_B[h]]),
      .s_i    (s_q),
      .term_o (term[h])
    );
  end

  always_comb begin
    for (int h = 0; h < CN; h++) begin
      acc[h]     = press_rd_q[h*AW +: AW];
      acc_sum[h] = {acc[h][AW-1], acc[h]} + {term[h][AW-1], term[h]};
      if (state_q == ptd_pkg::ST_CLEAR) begin
        press_wr[h*AW +: AW] = '0;
      end else if (acc_sum[h][AW] != acc_sum[h][AW-1]) begin
        press_wr[h*AW +: AW] = acc_sum[h][AW] ? ACC_MIN : ACC_MAX;
      end else begin
        press_wr[h*AW +: AW] = acc_sum[h][AW-1:0];
      end
    end
  end

  // ---------------- state machine ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptd_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ptd_pkg::ST_CLEAR: begin
        if (clr_cnt_q == SLOT_LAST) begin
          state_d = clr_resp_q ? ptd_pkg::ST_RESP : ptd_pkg::ST_IDLE;
        end
      end
      ptd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == ptd_pkg::CMD_CLEAR) begin
            state_d = ptd_pkg::ST_CLEAR;
          end else if (in_cmd == ptd_pkg::CMD_DEPOSIT && sp_ok) begin
            state_d = ptd_pkg::ST_MAP1;
          end else begin
            state_d = ptd_pkg::ST_RESP;
          end
        end
      end
      ptd_pkg::ST_MAP1: state_d = ptd_pkg::ST_MAP2;
      ptd_pkg::ST_MAP2: state_d = map_ok ? ptd_pkg::ST_ADDR : ptd_pkg::ST_RESP;
      ptd_pkg::ST_ADDR: state_d = ptd_pkg::ST_WGT;
      ptd_pkg::ST_WGT:  state_d = ptd_pkg::ST_SCL;
      ptd_pkg::ST_SCL:  state_d = ptd_pkg::ST_MAG;
      ptd_pkg::ST_MAG:  state_d = ptd_pkg::ST_PROD;
      ptd_pkg::ST_PROD: state_d = ptd_pkg::ST_TERM;
      ptd_pkg::ST_TERM: state_d = ptd_pkg::ST_WB;
      ptd_pkg::ST_WB: begin
        state_d = (corner_q == 3'd7) ? ptd_pkg::ST_RESP : ptd_pkg::ST_ADDR;
      end
      ptd_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = ptd_pkg::ST_IDLE;
        end
      end
      default: state_d = ptd_pkg::ST_IDLE;
    endcase
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q    <= 3'd0;
      clr_cnt_q   <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ptd_pkg::ST_CLEAR) begin
        clr_cnt_q <= (clr_cnt_q == SLOT_LAST) ? '0 : clr_cnt_q + SLOT_W'(1);
      end
      if (in_xfer) begin
        clr_resp_q <= (in_cmd == ptd_pkg::CMD_CLEAR);
      end
      if (state_q == ptd_pkg::ST_MAP2) begin
        corner_q <= 3'd0;
      end else if (state_q == ptd_pkg::ST_WB) begin
        corner_q <= corner_q + 3'd1;
      end
      if (state_q == ptd_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sp_q     <= species_i;
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      vel_q[0] <= vel_x_i;
      vel_q[1] <= vel_y_i;
      vel_q[2] <= vel_z_i;
      scale_q  <= species_scale_i;
      slot_q   <= in_slot;
      res_read_q <= (in_cmd == ptd_pkg::CMD_READ) && sp_ok && node_ok;
      if (in_cmd == ptd_pkg::CMD_CLEAR) begin
        res_status_q <= ptd_pkg::STS_OK;
      end else if (!sp_ok) begin
        res_status_q <= ptd_pkg::STS_BAD_IDX;
      end else if (in_cmd == ptd_pkg::CMD_DEPOSIT) begin
        res_status_q <= ptd_pkg::STS_OK;
      end else if (!node_ok) begin
        res_status_q <= ptd_pkg::STS_BAD_IDX;
      end else begin
        res_status_q <= ptd_pkg::STS_OK;
      end
    end
    if (state_q == ptd_pkg::ST_MAP1) begin
      for (int a = 0; a < 3; a++) begin
        cpos_q[a] <= 64'(pos_q[a]) * 64'(inv_q[a]) + 64'h8000_0000;
      end
    end
    if (state_q == ptd_pkg::ST_MAP2) begin
      cx_q <= CX_W'(ipo[0]);
      cy_q <= CY_W'(ipo[1]);
      cz_q <= CZ_W'(ipo[2]);
      for (int a = 0; a < 3; a++) begin
        frac_q[a] <= cpos_q[a][31:16];
      end
      if (!map_ok) begin
        res_status_q <= ptd_pkg::STS_OUTSIDE;
      end
    end
    if (state_q == ptd_pkg::ST_ADDR) begin
      slot_q <= node_slot;
      wxy_q  <= 34'(wx) * 34'(wy);
    end
    if (state_q == ptd_pkg::ST_WGT) begin
      w_q <= wprod[48:32];
    end
    if (state_q == ptd_pkg::ST_SCL) begin
      s_q <= sprod[48:16];
      for (int a = 0; a < 3; a++) begin
        d_q[a] <= d_sat[a];
      end
    end
    if (state_q == ptd_pkg::ST_RESP && out_free) begin
      out_status_q <= res_status_q;
      for (int h = 0; h < CN; h++) begin
        out_press_q[h] <= res_read_q ? press_rd_q[h*AW +: AW] : '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign press_xx_o  = out_press_q[0];
  assign press_xy_o  = out_press_q[1];
  assign press_xz_o  = out_press_q[2];
  assign press_yy_o  = out_press_q[3];
  assign press_yz_o  = out_press_q[4];
  assign press_zz_o  = out_press_q[5];

  // ---------------- assertions ----------------
  a_corner_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptd_pkg::ST_WB && corner_q != 3'd7) |=> (state_q == ptd_pkg::ST_ADDR))
    else $error("corner loop did not restart after write-back");

  a_no_write_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptd_pkg::ST_RESP) |-> !press_we)
    else $error("pressure memory written while a result is pending");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptd_pkg::ST_CLEAR) |-> (in_stall_o && !bulk_we))
    else $error("command taken during clear sweep");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptd_pkg::ST_RESP && out_free) |=> out_valid_o)
    else $error("result not presented after response state");

endmodule

[rtl/ptd_term_unit.sv]
// ----------------------------------------------------------------------------
// ptd_term_unit
// One tensor component: scale * |da| * |db| on magnitudes, clamped, signed.
// ----------------------------------------------------------------------------
module ptd_term_unit (
  input  logic                    clk_i,
  input  ptd_pkg::term_ctl_t      ctl_i,
  input  logic signed [31:0]      da_i,
  input  logic signed [31:0]      db_i,
  input  logic        [32:0]      s_i,
  output logic signed [47:0]      term_o
);

  localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h0000_8000_0000_0000;

  logic [31:0] ma, mb;
  logic [63:0] mprod;
  logic [47:0] m_q;
  logic        neg_q, neg2_q;
  logic [48:0] phi_q;
  logic [64:0] plo_q;
  logic [63:0] t_sum, t_clamp;
  logic signed [47:0] term_d, term_q;

  always_comb begin
    ma    = da_i[31] ? (~da_i + 32'd1) : da_i;
    mb    = db_i[31] ? (~db_i + 32'd1) : db_i;
    mprod = 64'(ma) * 64'(mb);
  end

  // sum wraps modulo 2^64
  always_comb begin
    t_sum = {phi_q[47:0], 16'b0} + 64'(plo_q[64:16]);
    if (neg2_q) begin
      t_clamp = (t_sum > NEG_MAX) ? NEG_MAX : t_sum;
      term_d  = ~t_clamp[47:0] + 48'd1;
    end else begin
      t_clamp = (t_sum > POS_MAX) ? POS_MAX : t_sum;
      term_d  = t_clamp[47:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mag_en) begin
      m_q   <= mprod[63:16];
      neg_q <= da_i[31] ^ db_i[31];
    end
    if (ctl_i.prod_en) begin
      phi_q  <= 49'(m_q[47:32]) * 49'(s_i);
      plo_q  <= 65'(m_q[31:0]) * 65'(s_i);
      neg2_q <= neg_q;
    end
    if (ctl_i.term_en) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

[verif/pic_pressure_tensor_deposit_tb.sv]
// ----------------------------------------------------------------------------
// pic_pressure_tensor_deposit_tb
// Drives clear, bulk-velocity load, particle deposit and node read commands
// through the command channel under several register settings, idle and output-stall mixes.
// A scoreboard keeps its own copy of the grid and predicts every result.
// ----------------------------------------------------------------------------
module pic_pressure_tensor_deposit_tb;

  localparam int GX = 32;
  localparam int GY = 32;
  localparam int GZ = 32;
  localparam int NSPEC = 2;
  localparam int NODES = GX * GY * GZ;
  localparam int SLOTS = NODES * NSPEC;
  localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    ptd_pkg::cmd_e       cmd;
    logic                species;
    logic [14:0]         node;
    logic [31:0]         pos [3];
    logic signed [31:0]  vel [3];
    logic [31:0]         scale;
  } cmd_item_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [47:0] p [6];
  } node_result_t;

  class pressure_board;
    logic [31:0]  inv_cell [3];
    logic [15:0]  origin [3];
    int           bulk [3][SLOTS];
    bit           loaded [SLOTS];
    longint       acc [6][SLOTS];
    node_result_t exp_q [$];
    int           errors;
    int           n_in, n_out, n_reads;

    function new();
      for (int a = 0; a < 3; a++) begin
        inv_cell[a] = 32'h0001_0000;
        origin[a] = '0;
      end
    endfunction

    // cell index and Q0.16 fraction along one axis; 0 when outside the grid
    function bit map_axis(int a, logic [31:0] pos, output int cell_idx, output int frac);
      logic [63:0] t;
      logic [63:0] ip;
      t = {32'b0, pos} * {32'b0, inv_cell[a]} + 64'h8000_0000;
      ip = t >> 32;
      cell_idx = 0;
      frac = 0;
      if (ip < origin[a]) return 0;
      ip = ip - origin[a];
      if (ip > 30) return 0;
      cell_idx = int'(ip);
      frac = int'(t[31:16]);
      return 1;
    endfunction

    function longint clip_diff(longint v, longint u);
      longint d;
      d = v - u;
      if (d > 64'sh7FFF_FFFF) d = 64'sh7FFF_FFFF;
      if (d < -64'sh8000_0000) d = -64'sh8000_0000;
      return d;
    endfunction

    function longint tensor_term(logic [63:0] s, longint da, longint db);
      bit neg;
      logic [63:0] ma, mb, m, hi, lo, t;
      neg = (da < 0) != (db < 0);
      ma = (da < 0) ? -da : da;
      mb = (db < 0) ? -db : db;
      m = (ma * mb) >> 16;
      hi = m >> 32;
      lo = m & 64'hFFFF_FFFF;
      t = ((hi * s) << 16) + ((lo * s) >> 16);
      if (neg) begin
        if (t > 64'h8000_0000_0000) t = 64'h8000_0000_0000;
        return -longint'(t);
      end
      if (t > 64'h7FFF_FFFF_FFFF) t = 64'h7FFF_FFFF_FFFF;
      return longint'(t);
    endfunction

    function int corner_slot(logic sp, int ci, int cj, int ck, int c);
      return int'(sp) * NODES + ((ci + (c & 1)) * GY + cj + ((c >> 1) & 1)) * GZ
             + ck + ((c >> 2) & 1);
    endfunction

    function void spread_particle(cmd_item_t it, int cl [3], int fr [3]);
      logic [63:0] wx, wy, wz, w, s;
      longint d [3];
      longint sum;
      int slot;
      for (int c = 0; c < 8; c++) begin
        wx = (c & 1) ? fr[0] : 65536 - fr[0];
        wy = (c & 2) ? fr[1] : 65536 - fr[1];
        wz = (c & 4) ? fr[2] : 65536 - fr[2];
        w = (wx * wy * wz) >> 32;
        s = (w * {32'b0, it.scale}) >> 16;
        slot = corner_slot(it.species, cl[0], cl[1], cl[2], c);
        for (int a = 0; a < 3; a++) d[a] = clip_diff(longint'(it.vel[a]), bulk[a][slot]);
        for (int h = 0; h < 6; h++) begin
          sum = acc[h][slot]
                + tensor_term(s, d[ptd_pkg::COMP_A[h]], d[ptd_pkg::COMP_B[h]]);
          if (sum > ACC_HI) sum = ACC_HI;
          if (sum < ACC_LO) sum = ACC_LO;
          acc[h][slot] = sum;
        end
      end
    endfunction

    function void note_command(cmd_item_t it);
      node_result_t r;
      int cl [3];
      int fr [3];
      bit in_grid;
      int slot;
      r.status = ptd_pkg::STS_OK;
      for (int h = 0; h < 6; h++) r.p[h] = '0;
      slot = int'(it.species) * NODES + int'(it.node);
      case (it.cmd)
        ptd_pkg::CMD_CLEAR: begin
          for (int h = 0; h < 6; h++)
            for (int i = 0; i < SLOTS; i++) acc[h][i] = 0;
        end
        ptd_pkg::CMD_LOAD: begin
          for (int a = 0; a < 3; a++) bulk[a][slot] = it.vel[a];
          loaded[slot] = 1;
        end
        ptd_pkg::CMD_DEPOSIT: begin
          in_grid = 1;
          for (int a = 0; a < 3; a++)
            if (in_grid) in_grid = map_axis(a, it.pos[a], cl[a], fr[a]);
          if (in_grid) spread_particle(it, cl, fr);
          else r.status = ptd_pkg::STS_OUTSIDE;
        end
        default: begin
          for (int h = 0; h < 6; h++) r.p[h] = acc[h][slot][47:0];
          n_reads++;
        end
      endcase
      exp_q.push_back(r);
      n_in++;
    endfunction

    function void check_result(node_result_t got);
      node_result_t want;
      n_out++;
      if (exp_q.size() == 0) begin
        $display("%0t: result with nothing pending, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = exp_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      for (int h = 0; h < 6; h++)
        if (got.p[h] !== want.p[h]) begin
          $display("%0t: component %0d expected %0d actual %0d", $time, h,
                   want.p[h], got.p[h]);
          errors++;
        end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ptd_pkg::ADDR_W-1:0] paddr = '0;
  logic [ptd_pkg::DATA_W-1:0] pwdata = '0;
  logic [ptd_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = '0;
  logic species_i = 1'b0;
  logic [14:0] node_index_i = '0;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [31:0] species_scale_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic signed [47:0] press_xx_o, press_xy_o, press_xz_o;
  logic signed [47:0] press_yy_o, press_yz_o, press_zz_o;

  pic_pressure_tensor_deposit #(
    .GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ), .SPECIES(NSPEC)
  ) DUT (.*);

  pressure_board board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int n_clears = 0;
  int n_deposits = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk_i) begin
    node_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_o;
      got.p[0] = press_xx_o;
      got.p[1] = press_xy_o;
      got.p[2] = press_xz_o;
      got.p[3] = press_yy_o;
      got.p[4] = press_yz_o;
      got.p[5] = press_zz_o;
      board.check_result(got);
    end
  end

  task automatic write_reg(ptd_pkg::reg_idx_e idx, logic [31:0] value);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx <= ptd_pkg::REG_INV_Z) board.inv_cell[idx] = value;
    else board.origin[idx - ptd_pkg::REG_ORG_X] = value[15:0];
  endtask

  task automatic set_grid(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                          logic [15:0] ox, logic [15:0] oy, logic [15:0] oz);
    // drain and let the block settle before touching registers
    in_valid_i = 1'b0;
    while (board.exp_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    write_reg(ptd_pkg::REG_INV_X, ix);
    write_reg(ptd_pkg::REG_INV_Y, iy);
    write_reg(ptd_pkg::REG_INV_Z, iz);
    write_reg(ptd_pkg::REG_ORG_X, {16'b0, ox});
    write_reg(ptd_pkg::REG_ORG_Y, {16'b0, oy});
    write_reg(ptd_pkg::REG_ORG_Z, {16'b0, oz});
  endtask

  task automatic send(cmd_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    cmd_i = it.cmd;
    species_i = it.species;
    node_index_i = it.node;
    pos_x_i = it.pos[0];
    pos_y_i = it.pos[1];
    pos_z_i = it.pos[2];
    vel_x_i = it.vel[0];
    vel_y_i = it.vel[1];
    vel_z_i = it.vel[2];
    species_scale_i = it.scale;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    board.note_command(it);
    if (it.cmd == ptd_pkg::CMD_CLEAR) n_clears++;
    if (it.cmd == ptd_pkg::CMD_DEPOSIT) n_deposits++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      default: return $signed($urandom()) >>> $urandom_range(0, 16);
    endcase
  endfunction

  function automatic cmd_item_t rand_item(ptd_pkg::cmd_e c);
    cmd_item_t it;
    it.cmd = c;
    it.species = 1'($urandom_range(0, 1));
    it.node = 15'($urandom_range(0, 32767));
    for (int a = 0; a < 3; a++) begin
      it.pos[a] = $urandom();
      it.vel[a] = rand_vel();
    end
    it.scale = $urandom() >> $urandom_range(0, 24);
    return it;
  endfunction

  // aim at a chosen cell; the mapping itself decides in or out
  function automatic logic [31:0] aim_axis(int a);
    logic [63:0] tgt, q;
    int c;
    if (board.inv_cell[a] == 0) return $urandom();
    c = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 30);
    tgt = ((64'(c) + board.origin[a]) << 32) + $urandom();
    if (tgt < 64'h8000_0000) tgt = 64'h8000_0000;
    q = (tgt - 64'h8000_0000) / board.inv_cell[a];
    if (q > 64'hFFFF_FFFF) return $urandom();
    return q[31:0];
  endfunction

  // load bulk velocity at every untouched corner, then deposit
  task automatic deposit_particle(cmd_item_t it);
    cmd_item_t ld;
    int cl [3];
    int fr [3];
    bit in_grid;
    int slot;
    in_grid = 1;
    for (int a = 0; a < 3; a++)
      if (in_grid) in_grid = board.map_axis(a, it.pos[a], cl[a], fr[a]);
    if (in_grid)
      for (int c = 0; c < 8; c++) begin
        slot = board.corner_slot(it.species, cl[0], cl[1], cl[2], c);
        if (!board.loaded[slot]) begin
          ld = rand_item(ptd_pkg::CMD_LOAD);
          ld.species = it.species;
          ld.node = 15'(slot % NODES);
          send(ld);
        end
      end
    it.cmd = ptd_pkg::CMD_DEPOSIT;
    send(it);
  endtask

  task automatic random_phase(int count);
    cmd_item_t it;
    int sel;
    for (int i = 0; i < count; i++) begin
      it = rand_item(ptd_pkg::CMD_READ);
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        if (sel < 47) for (int a = 0; a < 3; a++) it.pos[a] = aim_axis(a);
        deposit_particle(it);
      end else if (sel < 70) begin
        it.cmd = ptd_pkg::CMD_LOAD;
        if ($urandom_range(0, 1) != 0)
          it.node = 15'(($urandom_range(0, 4) * GY + $urandom_range(0, 4)) * GZ
                        + $urandom_range(0, 4));
        send(it);
      end else begin
        if ($urandom_range(0, 3) != 0)
          it.node = 15'(($urandom_range(0, 4) * GY + $urandom_range(0, 4)) * GZ
                        + $urandom_range(0, 4));
        send(it);
      end
    end
  endtask

  initial begin
    cmd_item_t it;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_grid(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'd0, 16'd0, 16'd0);

    // directed: centered particle, extreme velocities and scale, edges, reads, load, clear
    it = rand_item(ptd_pkg::CMD_DEPOSIT);
    it.species = 1'b0;
    it.pos = '{32'h0, 32'h0, 32'h0};
    it.vel = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000};
    it.scale = 32'hFFFF_FFFF;
    deposit_particle(it);
    it.vel = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
    deposit_particle(it);
    it.species = 1'b1;
    it.scale = 32'h0;
    it.pos = '{32'h001E_7FFF, 32'h001E_7FFF, 32'h001E_7FFF};
    deposit_particle(it);
    it.pos = '{32'h001E_8000, 32'h0, 32'h0};
    deposit_particle(it);
    it.pos = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    deposit_particle(it);
    it = rand_item(ptd_pkg::CMD_READ);
    it.species = 1'b0;
    it.node = 15'd0;
    send(it);
    it.node = 15'd1057;
    send(it);
    it.species = 1'b1;
    it.node = 15'h7FFF;
    send(it);
    it.cmd = ptd_pkg::CMD_LOAD;
    it.vel = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0};
    send(it);
    it.cmd = ptd_pkg::CMD_CLEAR;
    send(it);
    it.cmd = ptd_pkg::CMD_READ;
    it.species = 1'b0;
    it.node = 15'd0;
    send(it);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: set_grid('1, '1, '1, 16'd0, 16'd0, 16'd0);
        2: set_grid('0, '0, '0, 16'd0, 16'd0, 16'd0);
        3: set_grid(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                    16'hFFFF, 16'hFFFE, 16'd0);
        6: set_grid(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'd0, 16'd0, 16'd0);
        0: ;
        default: set_grid($urandom_range(32'h8000, 32'h40000),
                          $urandom_range(32'h8000, 32'h40000),
                          $urandom_range(32'h8000, 32'h40000),
                          16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                          16'($urandom_range(0, 40)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      if (ph == 3 || ph == 6) begin
        it = rand_item(ptd_pkg::CMD_CLEAR);
        send(it);
      end
      random_phase(50);
    end

    in_valid_i = 1'b0;
    while (board.exp_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    $display("covered %0d commands, %0d deposits, %0d node reads, %0d clears",
             board.n_in, n_deposits, board.n_reads, n_clears);
    $display("%0d results checked over eight register settings", board.n_out);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[pic_pressure_tensor_deposit.f]
rtl/ptd_pkg.sv
rtl/ptd_term_unit.sv
rtl/pic_pressure_tensor_deposit.sv
verif/pic_pressure_tensor_deposit_tb.sv
